// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file ded_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DED_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("deque check failed");

// Check that an expression never holds outside reset.
`define DED_ASSERT_NEVER(label, expr) \
   `DED_ASSERT(label, !(expr))

`endif

// ===== hw/rtl/ded_pkg.sv =====
package ded_pkg;

   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int POS_W    = 11;
   localparam int STATUS_W = 2;

   localparam logic [DATA_W-1:0] EMPTY_VALUE = {DATA_W{1'b1}};

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_BACK  = 3'd0,
      FN_PUSH_FRONT = 3'd1,
      FN_POP_BACK   = 3'd2,
      FN_POP_FRONT  = 3'd3,
      FN_INSERT     = 3'd4,
      FN_ERASE      = 3'd5,
      FN_QUERY      = 3'd6
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_BADPOS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD = 2'd0,
      CMD_INS  = 2'd1,
      CMD_DEL  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [DATA_W-1:0] item_value;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
      logic [POS_W-1:0]         element_count;
      logic                     is_empty;
   } rsp_type;

endpackage

// ===== hw/rtl/ded_cell.sv =====
module ded_cell import ded_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CW    = 11
) (
   input  logic              clock,
   input  cell_cmd_type      cmd,
   input  logic [CW-1:0]     pos,
   input  logic [CW-1:0]     back_idx,
   input  logic [DATA_W-1:0] left_data,
   input  logic [DATA_W-1:0] right_data,
   output logic [DATA_W-1:0] data,
   output logic [DATA_W-1:0] sel_data
);

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.kind)
         CMD_INS: begin
            // open a gap at pos: later words move one cell toward the back
            if (IDX > pos) begin
               data_in = left_data;
            end else if (IDX == pos) begin
               data_in = cmd.value;
            end
         end
         CMD_DEL: begin
            // close the gap at pos: later words move one cell toward the front
            if (IDX >= pos) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign sel_data = (IDX == back_idx) ? data_ff : '0;

endmodule

// ===== hw/rtl/ded_ctrl.sv =====
module ded_ctrl import ded_pkg::*; #(
   parameter int CAPACITY = 1024,
   parameter int CW       = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  req_type       req,
   output logic          busy,
   output cell_cmd_type  cmd,
   output logic [CW-1:0] pos,
   output logic [CW-1:0] back_idx,
   output logic          load_rsp,
   output status_type    status,
   output logic [CW-1:0] count
);

   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SEL   = 3'b010,
      ST_MERGE = 3'b100
   } state_type;

   state_type    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   status_type   status_ff, status_in;

   logic            accept;
   logic            full;
   logic            empty;
   logic [CMPW-1:0] cnt_ext;
   logic [CMPW-1:0] pos_ext;
   cmd_kind_type    kind_dec;
   logic [CW-1:0]   pos_dec;
   status_type      status_dec;
   logic [CW-1:0]   count_dec;

   assign accept  = start && (state_ff == ST_IDLE);
   assign full    = (count_ff == CW'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign cnt_ext = CMPW'(count_ff);
   assign pos_ext = CMPW'(req.position);

   always_comb begin
      kind_dec   = CMD_HOLD;
      pos_dec    = '0;
      status_dec = STAT_OK;
      count_dec  = count_ff;
      unique case (func_type'(req.func))
         FN_PUSH_BACK: begin
            if (full) begin
               status_dec = STAT_FULL;
            end else begin
               kind_dec  = CMD_INS;
               pos_dec   = count_ff;
               count_dec = count_ff + 1'b1;
            end
         end
         FN_PUSH_FRONT: begin
            if (full) begin
               status_dec = STAT_FULL;
            end else begin
               kind_dec  = CMD_INS;
               count_dec = count_ff + 1'b1;
            end
         end
         FN_POP_BACK: begin
            if (empty) begin
               status_dec = STAT_EMPTY;
            end else begin
               count_dec = count_ff - 1'b1;
            end
         end
         FN_POP_FRONT: begin
            if (empty) begin
               status_dec = STAT_EMPTY;
            end else begin
               kind_dec  = CMD_DEL;
               count_dec = count_ff - 1'b1;
            end
         end
         FN_INSERT: begin
            priority if (pos_ext > cnt_ext) begin
               status_dec = STAT_BADPOS;
            end else if (full) begin
               status_dec = STAT_FULL;
            end else begin
               kind_dec  = CMD_INS;
               pos_dec   = CW'(pos_ext);
               count_dec = count_ff + 1'b1;
            end
         end
         FN_ERASE: begin
            priority if (empty) begin
               status_dec = STAT_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               status_dec = STAT_BADPOS;
            end else begin
               kind_dec  = CMD_DEL;
               pos_dec   = CW'(pos_ext);
               count_dec = count_ff - 1'b1;
            end
         end
         default: begin
            status_dec = STAT_OK;
         end
      endcase
   end

   assign count_in  = accept ? count_dec : count_ff;
   assign status_in = accept ? status_dec : status_ff;

   always_comb begin
      unique case (state_ff)
         ST_IDLE:  state_in = accept ? ST_SEL : ST_IDLE;
         ST_SEL:   state_in = ST_MERGE;
         ST_MERGE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign cmd.kind  = accept ? kind_dec : CMD_HOLD;
   assign cmd.value = req.item_value;
   assign pos       = pos_dec;
   assign back_idx  = count_ff - 1'b1;
   assign load_rsp  = (state_ff == ST_MERGE);
   assign status    = status_ff;
   assign count     = count_ff;

endmodule

// ===== hw/rtl/double_ended_queue_engine_top.sv =====
// After the accepting edge the sequencer runs through a select state and a merge state;
// the result and its strobe are registered at the edge that ends the merge state.
// A new word is taken only back in idle; busy stays high in the select and merge states, in which
// the back word is picked out of the cell row by a two-level registered select.
// Pushes, inserts, erases and front pops shift the cells from the position on; back pops and queries move none.
// Reset clears the element count, the sequencer and the strobe; cells are not cleared.
module double_ended_queue_engine_top import ded_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int GS = 32;
   localparam int NG = (CAPACITY + GS - 1) / GS;

   cell_cmd_type  cmd;
   logic [CW-1:0] pos;
   logic [CW-1:0] back_idx;
   logic          load_rsp;
   status_type    status;
   logic [CW-1:0] count;

   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] cell_sel  [CAPACITY];
   logic [DATA_W-1:0] group_ff  [NG];
   logic [DATA_W-1:0] group_in  [NG];
   logic [DATA_W-1:0] back_merge;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   ded_ctrl #(
      .CAPACITY (CAPACITY),
      .CW       (CW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_data),
      .busy     (busy),
      .cmd      (cmd),
      .pos      (pos),
      .back_idx (back_idx),
      .load_rsp (load_rsp),
      .status   (status),
      .count    (count)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_right
         assign right_w = cell_data[i+1];
      end

      ded_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .pos        (pos),
         .back_idx   (back_idx),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (cell_data[i]),
         .sel_data   (cell_sel[i])
      );
   end

   // first level: merge each group of selected words
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GS; k++) begin
            if (g * GS + k < CAPACITY) begin
               group_in[g] = group_in[g] | cell_sel[g * GS + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NG; g++) begin
         group_ff[g] <= group_in[g];
      end
   end

   // second level: merge the group results
   always_comb begin
      back_merge = '0;
      for (int g = 0; g < NG; g++) begin
         back_merge = back_merge | group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= load_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff.status        <= status;
         rsp_ff.element_count <= POS_W'(count);
         rsp_ff.is_empty      <= (count == '0);
         if (count == '0) begin
            rsp_ff.front_value <= EMPTY_VALUE;
            rsp_ff.back_value  <= EMPTY_VALUE;
         end else begin
            rsp_ff.front_value <= cell_data[0];
            rsp_ff.back_value  <= back_merge;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/ded_checker.sv =====
`include "assert_macros.svh"

module ded_checker import ded_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input req_type req_data,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   logic accept;

   assign accept = start && !busy;

   `DED_ASSERT(a_busy_after_accept, accept |=> busy)
   `DED_ASSERT(a_rsp_after_accept, accept |-> ##3 rsp_valid)
   `DED_ASSERT(a_rsp_single_cycle, rsp_valid |=> !rsp_valid)
   `DED_ASSERT(a_empty_matches_count,
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.element_count == '0)))
   `DED_ASSERT_NEVER(a_empty_ends_not_minus_one,
      rsp_valid && rsp_data.is_empty &&
      ((rsp_data.front_value != EMPTY_VALUE) || (rsp_data.back_value != EMPTY_VALUE)))

endmodule

bind double_ended_queue_engine_top ded_checker u_ded_checker (.*);

// ===== tb/double_ended_queue_engine_checker.sv =====
module double_ended_queue_engine_checker import ded_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding,
   output int      results_checked,
   output int      full_refusals
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [DATA_W-1:0] cells [CAPACITY];
   int head = 0;
   int held = 0;

   rsp_type expected_rsp [$];
   int fail_tally = 0;
   int checked_tally = 0;
   int full_tally = 0;

   assign mismatches      = fail_tally;
   assign outstanding     = expected_rsp.size();
   assign results_checked = checked_tally;
   assign full_refusals   = full_tally;

   function automatic int phys(input int i);
      return (head + i) % CAPACITY;
   endfunction

   // Open a hole at pos by moving the later elements one place toward the back.
   task automatic open_slot(input int pos, input logic [DATA_W-1:0] v);
      for (int i = held; i > pos; i--) begin
         cells[phys(i)] = cells[phys(i - 1)];
      end
      cells[phys(pos)] = v;
      held++;
   endtask

   task automatic deque_apply(input req_type w, output rsp_type r);
      int pos;
      status_type st;
      pos = int'(w.position);
      st = STAT_OK;
      case (w.func)
         FN_PUSH_BACK: begin
            if (held >= CAPACITY) st = STAT_FULL;
            else open_slot(held, w.item_value);
         end
         FN_PUSH_FRONT: begin
            if (held >= CAPACITY) begin
               st = STAT_FULL;
            end else begin
               head = (head + CAPACITY - 1) % CAPACITY;
               cells[head] = w.item_value;
               held++;
            end
         end
         FN_POP_BACK: begin
            if (held == 0) st = STAT_EMPTY;
            else held--;
         end
         FN_POP_FRONT: begin
            if (held == 0) begin
               st = STAT_EMPTY;
            end else begin
               head = (head + 1) % CAPACITY;
               held--;
            end
         end
         FN_INSERT: begin
            // position is checked before fullness
            if (pos > held) st = STAT_BADPOS;
            else if (held >= CAPACITY) st = STAT_FULL;
            else open_slot(pos, w.item_value);
         end
         FN_ERASE: begin
            if (held == 0) begin
               st = STAT_EMPTY;
            end else if (pos >= held) begin
               st = STAT_BADPOS;
            end else if (pos == 0) begin
               head = (head + 1) % CAPACITY;
               held--;
            end else begin
               for (int i = pos; i + 1 < held; i++) begin
                  cells[phys(i)] = cells[phys(i + 1)];
               end
               held--;
            end
         end
         default: begin
         end
      endcase

      r.status = st;
      if (held == 0) begin
         r.front_value = EMPTY_VALUE;
         r.back_value  = EMPTY_VALUE;
      end else begin
         r.front_value = cells[phys(0)];
         r.back_value  = cells[phys(held - 1)];
      end
      r.element_count = held[POS_W-1:0];
      r.is_empty      = (held == 0);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         head = 0;
         held = 0;
         expected_rsp.delete();
      end else begin
         // Check the result first: it always belongs to an older word.
         if (rsp_valid) begin
            got = rsp_data;
            if (expected_rsp.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10) begin
                  $display("%0t: result with no word pending:", $realtime);
                  $display("   st=%0d front=%h back=%h count=%0d empty=%b",
                     got.status, got.front_value, got.back_value,
                     got.element_count, got.is_empty);
               end
            end else begin
               want = expected_rsp[0];
               expected_rsp.delete(0);
               checked_tally++;
               if (got.status !== want.status || got.front_value !== want.front_value ||
                   got.back_value !== want.back_value ||
                   got.element_count !== want.element_count ||
                   got.is_empty !== want.is_empty) begin
                  fail_tally++;
                  if (fail_tally <= 10) begin
                     $display("%0t: mismatch expected st=%0d front=%h back=%h count=%0d empty=%b",
                        $realtime, want.status, want.front_value, want.back_value,
                        want.element_count, want.is_empty);
                     $display("%0t:          actual   st=%0d front=%h back=%h count=%0d empty=%b",
                        $realtime, got.status, got.front_value, got.back_value,
                        got.element_count, got.is_empty);
                  end
               end
            end
         end
         if (start && !busy) begin
            deque_apply(req_data, want);
            if (want.status == STAT_FULL) full_tally++;
            expected_rsp.insert(expected_rsp.size(), want);
         end
      end
   end

endmodule

// ===== tb/double_ended_queue_engine_top_tb.sv =====
module double_ended_queue_engine_top_tb import ded_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 1024;
   localparam int RANDOM_WORDS = 900;
   localparam int PHASE_WORDS = 225;
   localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
   localparam logic [DATA_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
   localparam logic [DATA_W-1:0] MOST_POSITIVE = 32'h7fff_ffff;
   localparam logic [POS_W-1:0] TOP_POSITION = 11'd1024;

   localparam int MODE_MIX = 0;
   localparam int MODE_GROW = 1;
   localparam int MODE_SHRINK = 2;

   // sender idle percentage per pacing phase; the receiver cannot stall,
   // so its stall phase runs without idling
   localparam int PACE_PCT [4] = '{0, 66, 0, 15};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   int mismatches;
   int outstanding;
   int results_checked;
   int full_refusals;

   int words_sent = 0;
   int fill_est = 0;
   int peak_fill = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   double_ended_queue_engine_top #(.CAPACITY(CAPACITY)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   double_ended_queue_engine_checker #(.CAPACITY(CAPACITY)) deque_watch (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .full_refusals   (full_refusals)
   );

   function automatic req_type word_of(input logic [FUNC_W-1:0] f,
                                       input logic [DATA_W-1:0] v,
                                       input logic [POS_W-1:0] p);
      req_type w;
      w.func = f;
      w.item_value = v;
      w.position = p;
      return w;
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return '0;
         1: return EMPTY_VALUE;
         2: return MOST_NEGATIVE;
         3: return MOST_POSITIVE;
         default: return $urandom;
      endcase
   endfunction

   // Mostly legal positions against the running fill level, some noise.
   function automatic req_type pick_word(input int mode);
      req_type w;
      int r;
      int lean;
      lean = mode;
      if (mode == MODE_MIX) begin
         if (fill_est > 40) lean = MODE_SHRINK;
         else if (fill_est < 2 && $urandom_range(1)) lean = MODE_GROW;
      end
      r = $urandom_range(99);
      w.item_value = pick_value();
      w.position = POS_W'($urandom_range(CAPACITY));
      if (lean == MODE_GROW) begin
         if (r < 30) w.func = FN_PUSH_BACK;
         else if (r < 60) w.func = FN_PUSH_FRONT;
         else if (r < 90) w.func = FN_INSERT;
         else w.func = FUNC_W'($urandom_range(7));
      end else if (lean == MODE_SHRINK) begin
         if (r < 30) w.func = FN_POP_BACK;
         else if (r < 60) w.func = FN_POP_FRONT;
         else if (r < 90) w.func = FN_ERASE;
         else w.func = FN_QUERY;
      end else begin
         if (r < 14) w.func = FN_PUSH_BACK;
         else if (r < 28) w.func = FN_PUSH_FRONT;
         else if (r < 40) w.func = FN_POP_BACK;
         else if (r < 52) w.func = FN_POP_FRONT;
         else if (r < 70) w.func = FN_INSERT;
         else if (r < 86) w.func = FN_ERASE;
         else if (r < 96) w.func = FN_QUERY;
         else w.func = FN_UNUSED;
      end
      if ($urandom_range(99) < 85) begin
         if (w.func == FN_INSERT) begin
            w.position = POS_W'($urandom_range(fill_est));
         end else if (w.func == FN_ERASE && fill_est > 0) begin
            w.position = POS_W'($urandom_range(fill_est - 1));
         end
      end
      return w;
   endfunction

   task automatic send_word(input req_type w);
      // idle the sender at the rate of the current pacing phase
      while ($urandom_range(99) < PACE_PCT[(words_sent / PHASE_WORDS) % 4]) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_data <= w;
      start <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      words_sent++;
      case (w.func)
         FN_PUSH_BACK, FN_PUSH_FRONT: if (fill_est < CAPACITY) fill_est++;
         FN_INSERT: if (w.position <= fill_est && fill_est < CAPACITY) fill_est++;
         FN_POP_BACK, FN_POP_FRONT: if (fill_est > 0) fill_est--;
         FN_ERASE: if (w.position < fill_est) fill_est--;
         default: begin
         end
      endcase
      if (fill_est > peak_fill) peak_fill = fill_est;
   endtask

   initial begin
      #2_000_000;
      $display("double_ended_queue_engine_top_tb: FAIL");
      $finish;
   end

   initial begin
      int guard;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue corners, then build and pick apart a short queue
      send_word(word_of(FN_QUERY, '0, '0));
      send_word(word_of(FN_UNUSED, EMPTY_VALUE, TOP_POSITION));
      send_word(word_of(FN_POP_BACK, '0, '0));
      send_word(word_of(FN_POP_FRONT, '0, '0));
      send_word(word_of(FN_ERASE, '0, '0));
      send_word(word_of(FN_ERASE, '0, TOP_POSITION));
      send_word(word_of(FN_INSERT, MOST_POSITIVE, 11'd1));
      send_word(word_of(FN_INSERT, MOST_POSITIVE, TOP_POSITION));
      send_word(word_of(FN_INSERT, MOST_POSITIVE, 11'd0));
      send_word(word_of(FN_PUSH_BACK, MOST_NEGATIVE, '0));
      send_word(word_of(FN_PUSH_FRONT, '0, '0));
      send_word(word_of(FN_PUSH_FRONT, EMPTY_VALUE, '0));
      send_word(word_of(FN_INSERT, 32'h5555_5555, 11'd2));
      send_word(word_of(FN_INSERT, 32'haaaa_aaaa, 11'd5));
      send_word(word_of(FN_ERASE, '0, 11'd0));
      send_word(word_of(FN_ERASE, '0, 11'd2));
      send_word(word_of(FN_ERASE, '0, 11'd4));
      send_word(word_of(FN_ERASE, '0, 11'd3));
      send_word(word_of(FN_INSERT, 32'h1234_5678, TOP_POSITION));
      send_word(word_of(FN_POP_BACK, '0, '0));
      send_word(word_of(FN_POP_FRONT, '0, '0));
      send_word(word_of(FN_QUERY, '0, '0));

      repeat (RANDOM_WORDS) send_word(pick_word(MODE_MIX));
      start <= 1'b0;

      guard = 0;
      while (outstanding != 0 && guard < 200) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d words (peak fill %0d of %0d) over four pacing phases;",
         words_sent, peak_fill, CAPACITY);
      $display("checked %0d results, %0d of them refused as full.",
         results_checked, full_refusals);
      if (mismatches == 0 && outstanding == 0) begin
         $display("double_ended_queue_engine_top_tb: PASS");
      end else begin
         $display("double_ended_queue_engine_top_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ded_pkg.sv
hw/rtl/ded_cell.sv
hw/rtl/ded_ctrl.sv
hw/rtl/double_ended_queue_engine_top.sv
hw/rtl/ded_checker.sv
tb/double_ended_queue_engine_checker.sv
tb/double_ended_queue_engine_top_tb.sv
